@@ src/srj_pkg.sv @@
// Shared types, constants and helpers for the stereo reprojection Jacobian block.
package srj_pkg;

	typedef logic signed [31:0] q30_t;
	typedef logic signed [31:0] q16_t;
	typedef logic signed [63:0] wide_t;
	typedef logic signed [66:0] acc_t;

	typedef enum logic [1:0] {
		CFG_FOCAL_X,
		CFG_FOCAL_Y,
		CFG_BASELINE_FOCAL
	} cfg_idx_t;

	localparam int CFG_W = 31;
	localparam logic [CFG_W-1:0] FOCAL_X_RST = 31'd32768000;
	localparam logic [CFG_W-1:0] FOCAL_Y_RST = 31'd32768000;
	localparam logic [CFG_W-1:0] BASELINE_FOCAL_RST = 31'd2621440;

	localparam int ROWS = 3;
	localparam int NPOSE = 6;

	// multiplier magnitude cap, 2^62
	localparam logic [63:0] CAP_MAG = 64'h4000_0000_0000_0000;
	localparam logic [5:0] SH_Q30 = 6'd30;
	localparam logic [5:0] SH_Q32 = 6'd32;
	localparam logic [5:0] SH_IZ = 6'd14;
	localparam wide_t ONE32 = 64'sh0000_0001_0000_0000;
	localparam logic [63:0] MIN_DEPTH = 64'd256;

	// reciprocal divider: 2^62 / depth, 63 quotient bits
	localparam int QUO_W = 63;
	localparam int DEN_W = 35;
	localparam int DIV_STEP = 8;
	localparam int DIV_STAGES = (QUO_W + DIV_STEP - 1) / DIV_STEP;

	// item timing: accept-to-final-rows depth, and the depth flag's delay from the camera point
	localparam int PIPE_LAT = 23;
	localparam int BAD_LAT = PIPE_LAT - 6;

	function automatic q16_t sat32(input acc_t v);
		q16_t r;
		if (v > 67'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -67'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic wide_t clamp62(input acc_t v);
		wide_t r;
		if (v > 67'sh4000_0000_0000_0000)
			r = 64'sh4000_0000_0000_0000;
		else if (v < -67'sh4000_0000_0000_0000)
			r = -64'sh4000_0000_0000_0000;
		else
			r = v[63:0];
		return r;
	endfunction

	function automatic wide_t quad4(input q30_t r);
		wide_t e;
		e = 64'(r);
		return e <<< 2;
	endfunction

endpackage

@@ src/srj_mul.sv @@
// Two-stage sign-magnitude multiplier: product shifted right, truncated, capped at 2^62.
module srj_mul (
	input  logic               clk,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	input  logic [5:0]         sh,
	output logic signed [63:0] p
);
	import srj_pkg::*;

	logic [63:0] ua, ub;
	logic [63:0] pp0_s1, pp1_s1, pp2_s1, pp3_s1;
	logic neg_s1;
	logic [5:0] sh_s1;
	logic [127:0] prod, shifted;
	logic [63:0] mag;

	always_comb begin
		ua = a[63] ? 64'(-a) : 64'(a);
		ub = b[63] ? 64'(-b) : 64'(b);
	end

	// split into four 32x32 partial products
	always_ff @(posedge clk) begin
		pp0_s1 <= ua[31:0] * ub[31:0];
		pp1_s1 <= ua[31:0] * ub[63:32];
		pp2_s1 <= ua[63:32] * ub[31:0];
		pp3_s1 <= ua[63:32] * ub[63:32];
		neg_s1 <= a[63] ^ b[63];
		sh_s1 <= sh;
	end

	always_comb begin
		prod = {64'd0, pp0_s1} + {32'd0, pp1_s1, 32'd0} + {32'd0, pp2_s1, 32'd0}
			+ {pp3_s1, 64'd0};
		shifted = prod >> sh_s1;
		if (shifted > {64'd0, CAP_MAG})
			mag = CAP_MAG;
		else
			mag = shifted[63:0];
	end

	always_ff @(posedge clk) begin
		p <= neg_s1 ? -$signed(mag) : $signed(mag);
	end

endmodule

@@ src/srj_div.sv @@
// Pipelined restoring divider forming 2^62 / depth, eight quotient bits per stage, seven in the last.
module srj_div (
	input  logic                       clk,
	input  logic [srj_pkg::DEN_W-1:0]  den,
	output logic [srj_pkg::QUO_W-1:0]  quo
);
	import srj_pkg::*;

	logic [DEN_W:0]   rem_s [1:DIV_STAGES];
	logic [QUO_W-1:0] quo_s [1:DIV_STAGES];
	logic [DEN_W-1:0] den_s [1:DIV_STAGES];

	for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
		logic [DEN_W:0]   rem_in, rem_c;
		logic [QUO_W-1:0] quo_in, quo_c;
		logic [DEN_W-1:0] den_in;

		if (s == 0) begin : g_first
			assign rem_in = '0;
			assign quo_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[s];
			assign quo_in = quo_s[s];
			assign den_in = den_s[s];
		end

		always_comb begin
			rem_c = rem_in;
			quo_c = quo_in;
			for (int j = 0; j < DIV_STEP; j++) begin
				if (QUO_W - 1 - DIV_STEP * s - j >= 0) begin
					// dividend has only its top bit set
					rem_c = {rem_c[DEN_W-1:0], (s == 0 && j == 0)};
					if (rem_c >= {1'b0, den_in}) begin
						rem_c = rem_c - {1'b0, den_in};
						quo_c = {quo_c[QUO_W-2:0], 1'b1};
					end else begin
						quo_c = {quo_c[QUO_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			rem_s[s+1] <= rem_c;
			quo_s[s+1] <= quo_c;
			den_s[s+1] <= den_in;
		end
	end

	assign quo = quo_s[DIV_STAGES];

endmodule

@@ src/srj_xform.sv @@
// Rotation matrix from the quaternion and camera-frame point R*p+t.
module srj_xform (
	input  logic                clk,
	input  srj_pkg::q30_t       qw,
	input  srj_pkg::q30_t       qx,
	input  srj_pkg::q30_t       qy,
	input  srj_pkg::q30_t       qz,
	input  logic signed [31:0]  trans [3],
	input  logic signed [31:0]  pnt [3],
	output srj_pkg::wide_t      cam [3],
	output srj_pkg::q30_t       rot [9]
);
	import srj_pkg::*;

	wide_t m1_a [9], m1_b [9], m1_p [9];
	wide_t m2_a [9], m2_b [9], m2_p [9];
	acc_t e [9];
	acc_t one30;
	acc_t rc [9];
	logic signed [31:0] pnt_s1 [3], pnt_s2 [3], pnt_s3 [3];
	logic signed [31:0] t_s1 [3], t_s2 [3], t_s3 [3], t_s4 [3], t_s5 [3];
	q30_t rot_s3 [9], rot_s4 [9], rot_s5 [9];

	// products: xx yy zz xy xz yz wx wy wz
	always_comb begin
		m1_a[0] = 64'(qx); m1_b[0] = 64'(qx);
		m1_a[1] = 64'(qy); m1_b[1] = 64'(qy);
		m1_a[2] = 64'(qz); m1_b[2] = 64'(qz);
		m1_a[3] = 64'(qx); m1_b[3] = 64'(qy);
		m1_a[4] = 64'(qx); m1_b[4] = 64'(qz);
		m1_a[5] = 64'(qy); m1_b[5] = 64'(qz);
		m1_a[6] = 64'(qw); m1_b[6] = 64'(qx);
		m1_a[7] = 64'(qw); m1_b[7] = 64'(qy);
		m1_a[8] = 64'(qw); m1_b[8] = 64'(qz);
	end

	for (genvar gi = 0; gi < 9; gi++) begin : g_l1
		srj_mul u_mul (.clk(clk), .a(m1_a[gi]), .b(m1_b[gi]), .sh(SH_Q30), .p(m1_p[gi]));
	end

	always_comb begin
		one30 = 67'sd1073741824;
		for (int i = 0; i < 9; i++)
			e[i] = 67'(m1_p[i]);
		rc[0] = one30 - 2 * (e[1] + e[2]);
		rc[1] = 2 * (e[3] - e[8]);
		rc[2] = 2 * (e[4] + e[7]);
		rc[3] = 2 * (e[3] + e[8]);
		rc[4] = one30 - 2 * (e[0] + e[2]);
		rc[5] = 2 * (e[5] - e[6]);
		rc[6] = 2 * (e[4] - e[7]);
		rc[7] = 2 * (e[5] + e[6]);
		rc[8] = one30 - 2 * (e[0] + e[1]);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pnt_s1[i] <= pnt[i];
			pnt_s2[i] <= pnt_s1[i];
			pnt_s3[i] <= pnt_s2[i];
			t_s1[i] <= trans[i];
			t_s2[i] <= t_s1[i];
			t_s3[i] <= t_s2[i];
			t_s4[i] <= t_s3[i];
			t_s5[i] <= t_s4[i];
		end
		for (int i = 0; i < 9; i++) begin
			rot_s3[i] <= sat32(rc[i]);
			rot_s4[i] <= rot_s3[i];
			rot_s5[i] <= rot_s4[i];
			rot[i] <= rot_s5[i];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				m2_a[3*i+k] = 64'(rot_s3[3*i+k]);
				m2_b[3*i+k] = 64'(pnt_s3[k]);
			end
		end
	end

	for (genvar gi = 0; gi < 9; gi++) begin : g_l2
		srj_mul u_mul (.clk(clk), .a(m2_a[gi]), .b(m2_b[gi]), .sh(SH_Q30), .p(m2_p[gi]));
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			cam[i] <= 64'(67'(m2_p[3*i]) + 67'(m2_p[3*i+1]) + 67'(m2_p[3*i+2])
				+ 67'(t_s5[i]));
	end

endmodule

@@ src/srj_jac.sv @@
// Jacobian rows from camera point and reciprocal depth: four multiplier levels.
module srj_jac (
	input  logic                        clk,
	input  srj_pkg::wide_t              cx,
	input  srj_pkg::wide_t              cy,
	input  srj_pkg::q30_t               rot [9],
	input  logic                        negz,
	input  logic [srj_pkg::QUO_W-1:0]   quo,
	input  logic [srj_pkg::CFG_W-1:0]   fx,
	input  logic [srj_pkg::CFG_W-1:0]   fy,
	input  logic [srj_pkg::CFG_W-1:0]   bf,
	output srj_pkg::q16_t               jp [3][3],
	output srj_pkg::q16_t               jq [3][6]
);
	import srj_pkg::*;

	wide_t iz46, fxw, fyw, bfw;
	wide_t m3_a [3], m3_b [3], m3_p [3];
	wide_t m4_a [12], m4_b [12], m4_p [12];
	wide_t m5_a [22], m5_b [22], m5_p [22];
	wide_t m6_a [9], m6_b [9], m6_p [9];
	q30_t rot_p [5][9];
	wide_t a_s17, b_s17, iz_s17, a_s18, b_s18, iz_s18;
	wide_t a_s19, b_s19, iz_s19, izz_s19, ab_s19, aa_s19, bb_s19, aiz_s19, biz_s19;
	wide_t d0_s19 [3], d1_s19 [3];
	wide_t n_s22 [13], n_s23 [13];

	always_comb begin
		iz46 = negz ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		fxw = $signed({33'd0, fx});
		fyw = $signed({33'd0, fy});
		bfw = $signed({33'd0, bf});
		m3_a[0] = cx;   m3_b[0] = iz46;
		m3_a[1] = cy;   m3_b[1] = iz46;
		m3_a[2] = iz46; m3_b[2] = 64'sd1;
	end

	// a = x/z, b = y/z, iz = 1/z
	for (genvar gi = 0; gi < 3; gi++) begin : g_l3
		srj_mul u_mul (.clk(clk), .a(m3_a[gi]), .b(m3_b[gi]),
			.sh((gi == 2) ? SH_IZ : SH_Q30), .p(m3_p[gi]));
	end

	always_ff @(posedge clk) begin
		rot_p[0] <= rot;
		for (int i = 1; i < 5; i++)
			rot_p[i] <= rot_p[i-1];
		a_s17 <= m3_p[0];
		b_s17 <= m3_p[1];
		iz_s17 <= m3_p[2];
		a_s18 <= a_s17;
		b_s18 <= b_s17;
		iz_s18 <= iz_s17;
	end

	always_comb begin
		m4_a[0] = m3_p[2]; m4_b[0] = m3_p[2];
		m4_a[1] = m3_p[0]; m4_b[1] = m3_p[1];
		m4_a[2] = m3_p[0]; m4_b[2] = m3_p[0];
		m4_a[3] = m3_p[1]; m4_b[3] = m3_p[1];
		m4_a[4] = m3_p[0]; m4_b[4] = m3_p[2];
		m4_a[5] = m3_p[1]; m4_b[5] = m3_p[2];
		for (int k = 0; k < 3; k++) begin
			m4_a[6+k] = m3_p[0]; m4_b[6+k] = 64'(rot_p[1][6+k]);
			m4_a[9+k] = m3_p[1]; m4_b[9+k] = 64'(rot_p[1][6+k]);
		end
	end

	for (genvar gi = 0; gi < 12; gi++) begin : g_l4
		srj_mul u_mul (.clk(clk), .a(m4_a[gi]), .b(m4_b[gi]),
			.sh((gi < 6) ? SH_Q32 : SH_Q30), .p(m4_p[gi]));
	end

	always_ff @(posedge clk) begin
		izz_s19 <= m4_p[0];
		ab_s19 <= m4_p[1];
		aa_s19 <= m4_p[2];
		bb_s19 <= m4_p[3];
		aiz_s19 <= m4_p[4];
		biz_s19 <= m4_p[5];
		a_s19 <= a_s18;
		b_s19 <= b_s18;
		iz_s19 <= iz_s18;
		for (int k = 0; k < 3; k++) begin
			d0_s19[k] <= clamp62(67'(m4_p[6+k]) - 67'(quad4(rot_p[3][k])));
			d1_s19[k] <= clamp62(67'(m4_p[9+k]) - 67'(quad4(rot_p[3][3+k])));
		end
	end

	always_comb begin
		m5_a[0] = fxw;  m5_b[0] = ab_s19;
		m5_a[1] = fxw;  m5_b[1] = ONE32 + aa_s19;
		m5_a[2] = fxw;  m5_b[2] = b_s19;
		m5_a[3] = fxw;  m5_b[3] = iz_s19;
		m5_a[4] = fxw;  m5_b[4] = aiz_s19;
		m5_a[5] = fyw;  m5_b[5] = ONE32 + bb_s19;
		m5_a[6] = fyw;  m5_b[6] = ab_s19;
		m5_a[7] = fyw;  m5_b[7] = a_s19;
		m5_a[8] = fyw;  m5_b[8] = iz_s19;
		m5_a[9] = fyw;  m5_b[9] = biz_s19;
		m5_a[10] = bfw; m5_b[10] = biz_s19;
		m5_a[11] = bfw; m5_b[11] = aiz_s19;
		m5_a[12] = bfw; m5_b[12] = izz_s19;
		for (int k = 0; k < 3; k++) begin
			m5_a[13+k] = d0_s19[k]; m5_b[13+k] = iz_s19;
			m5_a[16+k] = d1_s19[k]; m5_b[16+k] = iz_s19;
			m5_a[19+k] = quad4(rot_p[4][6+k]); m5_b[19+k] = izz_s19;
		end
	end

	for (genvar gi = 0; gi < 22; gi++) begin : g_l5
		srj_mul u_mul (.clk(clk), .a(m5_a[gi]), .b(m5_b[gi]), .sh(SH_Q32), .p(m5_p[gi]));
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			m6_a[k] = fxw;   m6_b[k] = m5_p[13+k];
			m6_a[3+k] = fyw; m6_b[3+k] = m5_p[16+k];
			m6_a[6+k] = bfw; m6_b[6+k] = m5_p[19+k];
		end
	end

	for (genvar gi = 0; gi < 9; gi++) begin : g_l6
		srj_mul u_mul (.clk(clk), .a(m6_a[gi]), .b(m6_b[gi]), .sh(SH_Q32), .p(m6_p[gi]));
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 13; i++) begin
			n_s22[i] <= m5_p[i];
			n_s23[i] <= n_s22[i];
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			jp[0][k] = sat32(67'(m6_p[k]));
			jp[1][k] = sat32(67'(m6_p[3+k]));
			jp[2][k] = sat32(67'(m6_p[k]) - 67'(m6_p[6+k]));
		end
		jq[0][0] = sat32(67'(n_s23[0]));
		jq[0][1] = sat32(-67'(n_s23[1]));
		jq[0][2] = sat32(67'(n_s23[2]));
		jq[0][3] = sat32(-67'(n_s23[3]));
		jq[0][4] = '0;
		jq[0][5] = sat32(67'(n_s23[4]));
		jq[1][0] = sat32(67'(n_s23[5]));
		jq[1][1] = sat32(-67'(n_s23[6]));
		jq[1][2] = sat32(-67'(n_s23[7]));
		jq[1][3] = '0;
		jq[1][4] = sat32(-67'(n_s23[8]));
		jq[1][5] = sat32(67'(n_s23[9]));
		jq[2][0] = sat32(67'(n_s23[0]) - 67'(n_s23[10]));
		jq[2][1] = sat32(67'(n_s23[11]) - 67'(n_s23[1]));
		jq[2][2] = sat32(67'(n_s23[2]));
		jq[2][3] = sat32(-67'(n_s23[3]));
		jq[2][4] = '0;
		jq[2][5] = sat32(67'(n_s23[4]) - 67'(n_s23[12]));
	end

endmodule

@@ src/stereo_reprojection_jacobian.sv @@
// Stereo reprojection Jacobian: top level with config registers, divider and row output.
// An item (pose and world point) is taken when start is high and busy is low; busy then
// stays high until each of its three rows has a slot on the result port, so items enter
// no faster than the port sends their rows. The datapath is a fixed pipeline of registered
// multipliers and an eight-stage reciprocal divider; rows 0, 1 and 2 of an item appear on
// consecutive cycles, each marked by result_strobe for one cycle. The receiver cannot hold
// rows off; each must be taken in the cycle it is shown.
// Register writes take effect at once and belong in idle periods.
module stereo_reprojection_jacobian (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic signed [31:0] quat_w,
	input  logic signed [31:0] quat_x,
	input  logic signed [31:0] quat_y,
	input  logic signed [31:0] quat_z,
	input  logic signed [31:0] trans_x,
	input  logic signed [31:0] trans_y,
	input  logic signed [31:0] trans_z,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic               result_strobe,
	output logic [1:0]         row_index,
	output logic               last_row,
	output logic signed [31:0] dpoint_0,
	output logic signed [31:0] dpoint_1,
	output logic signed [31:0] dpoint_2,
	output logic signed [31:0] dpose_0,
	output logic signed [31:0] dpose_1,
	output logic signed [31:0] dpose_2,
	output logic signed [31:0] dpose_3,
	output logic signed [31:0] dpose_4,
	output logic signed [31:0] dpose_5,
	output logic               depth_invalid
);
	import srj_pkg::*;

	logic [CFG_W-1:0] focal_x_q, focal_y_q, baseline_focal_q;
	logic [1:0] gap_q;
	logic [PIPE_LAT-1:0] vld_q;
	logic accept;
	logic signed [31:0] trans [3], pnt [3];
	wide_t cam [3];
	q30_t rot [9];
	logic [63:0] cabs;
	logic [DEN_W-1:0] uz;
	logic bad;
	logic [QUO_W-1:0] quo;
	wide_t cx_d [DIV_STAGES], cy_d [DIV_STAGES];
	q30_t rot_d [DIV_STAGES][9];
	logic negz_d [DIV_STAGES];
	logic bad_d [BAD_LAT];
	q16_t jp [3][3], jq [3][6];
	q16_t jp_q [3][3], jq_q [3][6];
	logic bad_q;
	logic emit_q;
	logic [1:0] cnt_q;

	assign busy = (gap_q != 2'd0);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q <= FOCAL_X_RST;
			focal_y_q <= FOCAL_Y_RST;
			baseline_focal_q <= BASELINE_FOCAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FOCAL_X:        focal_x_q <= cfg_data;
				CFG_FOCAL_Y:        focal_y_q <= cfg_data;
				CFG_BASELINE_FOCAL: baseline_focal_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold off the next item until all rows of this one have a slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= 2'd0;
			vld_q <= '0;
		end else begin
			if (accept)
				gap_q <= 2'(ROWS - 1);
			else if (gap_q != 2'd0)
				gap_q <= gap_q - 2'd1;
			vld_q <= {vld_q[PIPE_LAT-2:0], accept};
		end
	end

	always_comb begin
		trans[0] = trans_x; trans[1] = trans_y; trans[2] = trans_z;
		pnt[0] = point_x;   pnt[1] = point_y;   pnt[2] = point_z;
	end

	srj_xform u_xform (
		.clk(clk), .qw(quat_w), .qx(quat_x), .qy(quat_y), .qz(quat_z),
		.trans(trans), .pnt(pnt), .cam(cam), .rot(rot)
	);

	always_comb begin
		cabs = cam[2][63] ? 64'(-cam[2]) : 64'(cam[2]);
		uz = cabs[DEN_W-1:0];
		bad = (cabs < MIN_DEPTH);
	end

	srj_div u_div (.clk(clk), .den(uz), .quo(quo));

	// align camera point and rotation with the divider output
	always_ff @(posedge clk) begin
		cx_d[0] <= cam[0];
		cy_d[0] <= cam[1];
		rot_d[0] <= rot;
		negz_d[0] <= cam[2][63];
		for (int i = 1; i < DIV_STAGES; i++) begin
			cx_d[i] <= cx_d[i-1];
			cy_d[i] <= cy_d[i-1];
			rot_d[i] <= rot_d[i-1];
			negz_d[i] <= negz_d[i-1];
		end
		bad_d[0] <= bad;
		for (int i = 1; i < BAD_LAT; i++)
			bad_d[i] <= bad_d[i-1];
	end

	srj_jac u_jac (
		.clk(clk), .cx(cx_d[DIV_STAGES-1]), .cy(cy_d[DIV_STAGES-1]),
		.rot(rot_d[DIV_STAGES-1]), .negz(negz_d[DIV_STAGES-1]), .quo(quo),
		.fx(focal_x_q), .fy(focal_y_q), .bf(baseline_focal_q), .jp(jp), .jq(jq)
	);

	// capture the finished rows; drop the entries on a tiny depth
	always_ff @(posedge clk) begin
		if (vld_q[PIPE_LAT-1]) begin
			bad_q <= bad_d[BAD_LAT-1];
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++)
					jp_q[i][k] <= bad_d[BAD_LAT-1] ? '0 : jp[i][k];
				for (int k = 0; k < NPOSE; k++)
					jq_q[i][k] <= bad_d[BAD_LAT-1] ? '0 : jq[i][k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
			cnt_q <= 2'd0;
		end else if (vld_q[PIPE_LAT-1]) begin
			emit_q <= 1'b1;
			cnt_q <= 2'd0;
		end else if (emit_q) begin
			if (cnt_q == 2'(ROWS - 1))
				emit_q <= 1'b0;
			else
				cnt_q <= cnt_q + 2'd1;
		end
	end

	assign result_strobe = emit_q;
	assign row_index = cnt_q;
	assign last_row = (cnt_q == 2'(ROWS - 1));
	assign depth_invalid = bad_q;
	assign dpoint_0 = jp_q[cnt_q][0];
	assign dpoint_1 = jp_q[cnt_q][1];
	assign dpoint_2 = jp_q[cnt_q][2];
	assign dpose_0 = jq_q[cnt_q][0];
	assign dpose_1 = jq_q[cnt_q][1];
	assign dpose_2 = jq_q[cnt_q][2];
	assign dpose_3 = jq_q[cnt_q][3];
	assign dpose_4 = jq_q[cnt_q][4];
	assign dpose_5 = jq_q[cnt_q][5];

`ifndef ASSERT_OFF
	a_accept_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy ##1 busy)
		else $error("item accepted inside the three-cycle window");

	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_row |=> result_strobe && row_index == $past(row_index) + 2'd1)
		else $error("result rows out of sequence");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[PIPE_LAT-1] |-> !emit_q || last_row)
		else $error("finished item overwrites rows still being sent");

	a_pipe_sparse: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] |-> !vld_q[1] && !vld_q[2])
		else $error("two items closer than three cycles in the pipeline");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the stereo reprojection Jacobian block.
module testbench;
	import srj_pkg::*;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam longint CAP62 = 64'sh4000_0000_0000_0000;
	localparam int IDLE_LIMIT = 3000;

	typedef struct {
		q30_t qw, qx, qy, qz;
		q16_t tx, ty, tz;
		q16_t px, py, pz;
	} pose_point_t;

	typedef struct {
		logic [1:0] row;
		logic last;
		logic signed [31:0] dp[3];
		logic signed [31:0] dq[6];
		logic bad;
	} jac_row_t;

	logic clk, arst_n, start, busy, cfg_we;
	logic [1:0] cfg_index;
	logic [30:0] cfg_data;
	q30_t quat_w, quat_x, quat_y, quat_z;
	q16_t trans_x, trans_y, trans_z, point_x, point_y, point_z;
	logic result_strobe, last_row, depth_invalid;
	logic [1:0] row_index;
	logic signed [31:0] dpoint_0, dpoint_1, dpoint_2;
	logic signed [31:0] dpose_0, dpose_1, dpose_2, dpose_3, dpose_4, dpose_5;

	pose_point_t pending_items[$];
	jac_row_t expected_rows[$];
	longint focal_x_m, focal_y_m, bf_m;
	logic took;
	int gap_left;
	int mismatches, rows_seen, items_taken, bad_depth_rows, idle_cycles;

	stereo_reprojection_jacobian DUT (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// magnitude product, shifted and truncated toward zero, capped at 2^62
	function automatic longint mul_trunc(longint a, longint b, int sh);
		logic [63:0] ua, ub;
		logic [127:0] pr;
		longint r;
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		pr = {64'd0, ua} * {64'd0, ub};
		pr = pr >> sh;
		r = (pr > 128'(CAP62)) ? CAP62 : longint'(pr[63:0]);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic longint sat_q16(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint clamp_cap(longint v);
		if (v > CAP62) return CAP62;
		if (v < -CAP62) return -CAP62;
		return v;
	endfunction

	task automatic predict_rows(input pose_point_t it);
		longint qw, qx, qy, qz, xx, yy, zz, xy, xz, yz, wx, wy, wz;
		longint p[3], t[3], c[3], rot[3][3], jp[3][3], jq[3][6];
		longint one30, q46, iz46, a, b, iz, izz, ab, aa, bb, aiz, biz, d0, d1;
		logic [63:0] uz;
		logic bad;
		jac_row_t r;
		qw = it.qw; qx = it.qx; qy = it.qy; qz = it.qz;
		p[0] = it.px; p[1] = it.py; p[2] = it.pz;
		t[0] = it.tx; t[1] = it.ty; t[2] = it.tz;
		one30 = 64'sd1 << 30;
		xx = mul_trunc(qx, qx, 30); yy = mul_trunc(qy, qy, 30); zz = mul_trunc(qz, qz, 30);
		xy = mul_trunc(qx, qy, 30); xz = mul_trunc(qx, qz, 30); yz = mul_trunc(qy, qz, 30);
		wx = mul_trunc(qw, qx, 30); wy = mul_trunc(qw, qy, 30); wz = mul_trunc(qw, qz, 30);
		rot[0][0] = one30 - 2 * (yy + zz); rot[0][1] = 2 * (xy - wz); rot[0][2] = 2 * (xz + wy);
		rot[1][0] = 2 * (xy + wz); rot[1][1] = one30 - 2 * (xx + zz); rot[1][2] = 2 * (yz - wx);
		rot[2][0] = 2 * (xz - wy); rot[2][1] = 2 * (yz + wx); rot[2][2] = one30 - 2 * (xx + yy);
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++)
				rot[i][k] = sat_q16(rot[i][k]);
		for (int i = 0; i < 3; i++)
			c[i] = mul_trunc(rot[i][0], p[0], 30) + mul_trunc(rot[i][1], p[1], 30)
				+ mul_trunc(rot[i][2], p[2], 30) + t[i];
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) jp[i][k] = 0;
			for (int k = 0; k < 6; k++) jq[i][k] = 0;
		end
		uz = c[2] < 0 ? -c[2] : c[2];
		bad = uz < 64'd256;
		if (!bad) begin
			q46 = longint'((64'd1 << 62) / uz);
			iz46 = c[2] < 0 ? -q46 : q46;
			a = mul_trunc(c[0], iz46, 30);
			b = mul_trunc(c[1], iz46, 30);
			iz = mul_trunc(iz46, 1, 14);
			izz = mul_trunc(iz, iz, 32);
			ab = mul_trunc(a, b, 32); aa = mul_trunc(a, a, 32); bb = mul_trunc(b, b, 32);
			aiz = mul_trunc(a, iz, 32); biz = mul_trunc(b, iz, 32);
			for (int k = 0; k < 3; k++) begin
				d0 = clamp_cap(mul_trunc(a, rot[2][k], 30) - 4 * rot[0][k]);
				d1 = clamp_cap(mul_trunc(b, rot[2][k], 30) - 4 * rot[1][k]);
				jp[0][k] = mul_trunc(focal_x_m, mul_trunc(d0, iz, 32), 32);
				jp[1][k] = mul_trunc(focal_y_m, mul_trunc(d1, iz, 32), 32);
				jp[2][k] = jp[0][k] - mul_trunc(bf_m, mul_trunc(4 * rot[2][k], izz, 32), 32);
			end
			jq[0][0] = mul_trunc(focal_x_m, ab, 32);
			jq[0][1] = -mul_trunc(focal_x_m, ONE32 + aa, 32);
			jq[0][2] = mul_trunc(focal_x_m, b, 32);
			jq[0][3] = -mul_trunc(focal_x_m, iz, 32);
			jq[0][5] = mul_trunc(focal_x_m, aiz, 32);
			jq[1][0] = mul_trunc(focal_y_m, ONE32 + bb, 32);
			jq[1][1] = -mul_trunc(focal_y_m, ab, 32);
			jq[1][2] = -mul_trunc(focal_y_m, a, 32);
			jq[1][4] = -mul_trunc(focal_y_m, iz, 32);
			jq[1][5] = mul_trunc(focal_y_m, biz, 32);
			jq[2][0] = jq[0][0] - mul_trunc(bf_m, biz, 32);
			jq[2][1] = jq[0][1] + mul_trunc(bf_m, aiz, 32);
			jq[2][2] = jq[0][2];
			jq[2][3] = jq[0][3];
			jq[2][5] = jq[0][5] - mul_trunc(bf_m, izz, 32);
		end
		for (int i = 0; i < 3; i++) begin
			r.row = 2'(i);
			r.last = (i == 2);
			for (int k = 0; k < 3; k++) r.dp[k] = 32'(sat_q16(jp[i][k]));
			for (int k = 0; k < 6; k++) r.dq[k] = 32'(sat_q16(jq[i][k]));
			r.bad = bad;
			expected_rows.push_back(r);
		end
	endtask

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) return 0;
		if (roll < 92) return $urandom_range(1, 4);
		return $urandom_range(15, 45);
	endfunction

	// driver: hold an item until taken, then idle for a random gap
	always @(negedge clk) begin
		pose_point_t it;
		if (arst_n && !(start && !took)) begin
			if (start && took)
				gap_left = pick_gap();
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_items.size() > 0) begin
				it = pending_items.pop_front();
				quat_w <= it.qw; quat_x <= it.qx; quat_y <= it.qy; quat_z <= it.qz;
				trans_x <= it.tx; trans_y <= it.ty; trans_z <= it.tz;
				point_x <= it.px; point_y <= it.py; point_z <= it.pz;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: predict on accept, check each row strobe
	always @(posedge clk) begin
		pose_point_t it;
		jac_row_t e;
		logic signed [31:0] got_dp[3], got_dq[6];
		logic bad_row;
		logic active;
		active = 1'b0;
		took <= arst_n && start && !busy;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FOCAL_X: focal_x_m = cfg_data;
					CFG_FOCAL_Y: focal_y_m = cfg_data;
					CFG_BASELINE_FOCAL: bf_m = cfg_data;
					default: ;
				endcase
				active = 1'b1;
			end
			if (start && !busy) begin
				it.qw = quat_w; it.qx = quat_x; it.qy = quat_y; it.qz = quat_z;
				it.tx = trans_x; it.ty = trans_y; it.tz = trans_z;
				it.px = point_x; it.py = point_y; it.pz = point_z;
				predict_rows(it);
				items_taken++;
				active = 1'b1;
			end
			if (result_strobe) begin
				active = 1'b1;
				rows_seen++;
				if (depth_invalid) bad_depth_rows++;
				got_dp = '{dpoint_0, dpoint_1, dpoint_2};
				got_dq = '{dpose_0, dpose_1, dpose_2, dpose_3, dpose_4, dpose_5};
				if (expected_rows.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("row %0d with no item pending", row_index);
				end else begin
					e = expected_rows.pop_front();
					bad_row = e.row !== row_index || e.last !== last_row
						|| e.bad !== depth_invalid || e.dp != got_dp || e.dq != got_dq;
					if (bad_row) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("row mismatch: exp row %0d last %0d bad %0d, got %0d %0d %0d",
								e.row, e.last, e.bad, row_index, last_row, depth_invalid);
							$display("  exp dpoint %0d %0d %0d dpose %0d %0d %0d %0d %0d %0d",
								e.dp[0], e.dp[1], e.dp[2],
								e.dq[0], e.dq[1], e.dq[2], e.dq[3], e.dq[4], e.dq[5]);
							$display("  got dpoint %0d %0d %0d dpose %0d %0d %0d %0d %0d %0d",
								dpoint_0, dpoint_1, dpoint_2,
								dpose_0, dpose_1, dpose_2, dpose_3, dpose_4, dpose_5);
						end
					end
				end
			end
			idle_cycles <= active ? 0 : idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	function automatic pose_point_t make_item(longint w, longint x, longint y, longint z,
			longint tx, longint ty, longint tz, longint px, longint py, longint pz);
		pose_point_t it;
		it.qw = 32'(w); it.qx = 32'(x); it.qy = 32'(y); it.qz = 32'(z);
		it.tx = 32'(tx); it.ty = 32'(ty); it.tz = 32'(tz);
		it.px = 32'(px); it.py = 32'(py); it.pz = 32'(pz);
		return it;
	endfunction

	function automatic pose_point_t raw_item();
		return make_item($urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom);
	endfunction

	// random unit rotation, point a few meters in front of the camera
	function automatic pose_point_t scene_item();
		real w, x, y, z, n;
		w = $urandom_range(0, 2000) - 1000.0;
		x = $urandom_range(0, 2000) - 1000.0;
		y = $urandom_range(0, 2000) - 1000.0;
		z = $urandom_range(0, 2000) - 1000.0;
		n = $sqrt(w * w + x * x + y * y + z * z);
		if (n == 0.0) begin
			w = 1.0; n = 1.0;
		end
		return make_item($rtoi(w / n * 1073741824.0), $rtoi(x / n * 1073741824.0),
			$rtoi(y / n * 1073741824.0), $rtoi(z / n * 1073741824.0),
			longint'($urandom_range(0, 1 << 21)) - (1 << 20),
			longint'($urandom_range(0, 1 << 21)) - (1 << 20),
			longint'($urandom_range(8 << 16, 60 << 16)),
			longint'($urandom_range(0, 10 << 16)) - (5 << 16),
			longint'($urandom_range(0, 10 << 16)) - (5 << 16),
			longint'($urandom_range(0, 10 << 16)) - (5 << 16));
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || start || expected_rows.size() > 0)
			@(posedge clk);
		repeat (PIPE_LAT + 8) @(posedge clk);
	endtask

	task automatic random_batch(input int count);
		int roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 75)
				pending_items.push_back(scene_item());
			else if (roll < 85)
				pending_items.push_back(make_item(1 << 30, 0, 0, 0, 0, 0, 0,
					$urandom, $urandom, longint'($urandom_range(0, 1024)) - 512));
			else
				pending_items.push_back(raw_item());
		end
	endtask

	initial begin
		longint one, big, tiny;
		one = 64'sd1 << 30;
		tiny = 255;
		big = 64'sd2147483647;
		start = 0; cfg_we = 0; cfg_index = CFG_FOCAL_X; cfg_data = 0; took = 0;
		quat_w = 0; quat_x = 0; quat_y = 0; quat_z = 0;
		trans_x = 0; trans_y = 0; trans_z = 0; point_x = 0; point_y = 0; point_z = 0;
		focal_x_m = FOCAL_X_RST; focal_y_m = FOCAL_Y_RST; bf_m = BASELINE_FOCAL_RST;
		gap_left = 0; mismatches = 0; rows_seen = 0; items_taken = 0;
		bad_depth_rows = 0; idle_cycles = 0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed, with reset register values
		pending_items.push_back(make_item(one, 0, 0, 0, 0, 0, 0, 1 << 16, 2 << 16, 10 << 16));
		pending_items.push_back(make_item(one, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(one, 0, 0, 0, 0, 0, 0, 5 << 16, 5 << 16, tiny));
		pending_items.push_back(make_item(one, 0, 0, 0, 0, 0, 0, 5 << 16, 5 << 16, -tiny));
		pending_items.push_back(make_item(one, 0, 0, 0, 0, 0, 0, 5 << 16, -3 << 16, 256));
		pending_items.push_back(make_item(one, 0, 0, 0, 0, 0, 0, 5 << 16, -3 << 16, -256));
		pending_items.push_back(make_item(one, 0, 0, 0, 3 << 16, 1 << 16, -20 << 16,
			1 << 16, 2 << 16, 4 << 16));
		pending_items.push_back(make_item(0, one, 0, 0, 0, 0, 0, 1 << 16, 2 << 16, -7 << 16));
		pending_items.push_back(make_item(0, 0, one, 0, 0, 0, 0, 1 << 16, 2 << 16, -7 << 16));
		pending_items.push_back(make_item(0, 0, 0, one, 0, 0, 5 << 16, 1 << 16, 2 << 16, 1));
		pending_items.push_back(make_item(big, big, big, big, big, big, big, big, big, big));
		pending_items.push_back(make_item(-big - 1, -big - 1, -big - 1, -big - 1, -big - 1,
			-big - 1, -big - 1, -big - 1, -big - 1, -big - 1));
		pending_items.push_back(make_item(-one, one, -one, one, 0, 0, big, 0, 0, 0));
		pending_items.push_back(make_item(one, 0, 0, 0, big, -big - 1, 1 << 16, 0, 0, 0));
		pending_items.push_back(make_item(one, 0, 0, 0, 0, 0, 0, big, -big - 1, 256));
		pending_items.push_back(make_item(one >> 1, 0, 0, 0, 0, 0, 0, 3 << 16, 1 << 16, 9 << 16));
		pending_items.push_back(make_item(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
		pending_items.push_back(raw_item());
		pending_items.push_back(raw_item());
		random_batch(40);
		drain();

		// largest focal values
		write_reg(CFG_FOCAL_X, 31'h7fffffff);
		write_reg(CFG_FOCAL_Y, 31'h7fffffff);
		write_reg(CFG_BASELINE_FOCAL, 31'h7fffffff);
		pending_items.push_back(make_item(one, 0, 0, 0, 0, 0, 0, big, big, 256));
		random_batch(50);
		drain();

		// zero registers, plus a write to the unused index that must change nothing
		write_reg(CFG_FOCAL_X, 31'd0);
		write_reg(CFG_FOCAL_Y, 31'd0);
		write_reg(CFG_BASELINE_FOCAL, 31'd0);
		write_reg(CFG_UNUSED, 31'h7fffffff);
		random_batch(40);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			write_reg(CFG_FOCAL_X, 31'($urandom));
			write_reg(CFG_FOCAL_Y, 31'($urandom_range(100 << 16, 1500 << 16)));
			write_reg(CFG_BASELINE_FOCAL, 31'($urandom_range(0, 200 << 16)));
			random_batch(50);
			drain();
		end

		$display("%0d items, %0d rows checked (%0d with invalid depth) over 6 register settings",
			items_taken, rows_seen, bad_depth_rows);
		if (mismatches == 0 && expected_rows.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("%0d mismatching rows, %0d rows never seen", mismatches,
				expected_rows.size());
			$display("testbench failed");
		end
		$finish;
	end

endmodule
